/* sv/irt_pkg.sv */
package irt_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int KEY_WIDTH   = 16;
	localparam int VALUE_WIDTH = 8;

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	// scratch count reaches MAX_ENTRIES + 2 before the capacity check
	localparam int CNT_W = $clog2(MAX_ENTRIES + 3);
	localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		logic lt_lo;
		logic gt_hi;
	} cmp_t;

endpackage

/* sv/irt_ram.sv */
module irt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/irt_cmp.sv */
module irt_cmp (
	input  irt_pkg::key_t key,
	input  irt_pkg::key_t lo,
	input  irt_pkg::key_t hi,
	output irt_pkg::cmp_t res
);

	// signed order of breakpoint keys
	assign res.lt_lo = (key < lo);
	assign res.gt_hi = (key > hi);

endmodule

/* sv/interval_range_table.sv */
// Interval range table: a sorted breakpoint table mapping every signed key to a value.
// Input words arrive on s_tvalid/s_tready; s_tuser carries the command (0 assign an
// interval, 1 look up a key). One result word per input leaves on m_tvalid/m_tready.
// cfg_wr_en/cfg_wr_data set the default value; write it only while the block is idle.
// A lookup walks the stored breakpoints up to the query key; an assign takes one step
// per stored entry plus one each for the begin and end breakpoints. An empty interval
// (begin not below end) skips the walk and returns status 1.
// One key comparator and one memory read port walk the table one entry per cycle,
// apart from the begin and end steps; the block takes one word at a time.
// The table sits in two banks of one RAM: an assign reads the live bank and writes
// the rebuilt, canonical table into the other, then swaps banks when it fits. A
// rebuild that would need more than MAX_ENTRIES breakpoints is dropped (status 2).
// Reset empties the table at once and clears the default to zero.
// A finished result sits in the output register; while the receiver stalls on an
// earlier result, the block waits before loading the new one and returning to idle.
module interval_range_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] interval_begin, [31:16] interval_end, [39:32] new_value, [55:40] query_key
	input  logic [55:0] s_tdata,
	// [0] command
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] found_value, [9:8] status, [15:10] zero
	output logic [15:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic [irt_pkg::VALUE_WIDTH-1:0] cfg_wr_data
);

	localparam int KW = irt_pkg::KEY_WIDTH;
	localparam int VW = irt_pkg::VALUE_WIDTH;
	localparam int CW = irt_pkg::CNT_W;
	localparam int IW = irt_pkg::IDX_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]      state_q;
	logic            lookup_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   wr_q;
	logic [CW-1:0]   count_q;
	logic            bank_q;
	logic            begin_done_q;
	logic            end_done_q;
	irt_pkg::value_t last_q;
	irt_pkg::value_t run_q;
	irt_pkg::value_t def_q;
	irt_pkg::value_t nv_q;
	irt_pkg::key_t   lo_q;
	irt_pkg::key_t   hi_q;
	logic [irt_pkg::STATUS_W-1:0] status_q;
	logic            out_valid_q;
	logic [15:0]     out_data_q;

	logic [irt_pkg::ENTRY_W-1:0] rd_data;
	irt_pkg::key_t   rd_key;
	irt_pkg::value_t rd_val;
	irt_pkg::cmp_t   cmp;
	logic            at_end;
	logic            advance;
	logic            done;
	logic            em_req;
	irt_pkg::key_t   em_key;
	irt_pkg::value_t em_val;
	logic            em_new;
	logic            ram_we;
	logic [IW-1:0]   rd_idx;
	logic            out_free;
	irt_pkg::key_t   in_begin;
	irt_pkg::key_t   in_end;

	assign rd_key = rd_data[KW-1:0];
	assign rd_val = rd_data[KW+VW-1:KW];
	assign at_end = (idx_q == count_q);
	assign in_begin = s_tdata[15:0];
	assign in_end   = s_tdata[31:16];

	irt_cmp u_cmp (
		.key(rd_key),
		.lo (lo_q),
		.hi (hi_q),
		.res(cmp)
	);

	// one step of the walk: emit at most one breakpoint, advance, or both, or finish
	always_comb begin
		advance = 1'b0;
		done    = 1'b0;
		em_req  = 1'b0;
		em_key  = rd_key;
		em_val  = rd_val;
		if (state_q == ST_EVAL) begin
			if (lookup_q) begin
				if (at_end || cmp.gt_hi) begin
					done = 1'b1;
				end else begin
					advance = 1'b1;
				end
			end else if (!begin_done_q && (at_end || !cmp.lt_lo)) begin
				em_req = 1'b1;
				em_key = lo_q;
				em_val = nv_q;
			end else if (!end_done_q && (at_end || cmp.gt_hi)) begin
				em_req = 1'b1;
				em_key = hi_q;
				em_val = run_q;
			end else if (at_end) begin
				done = 1'b1;
			end else begin
				advance = 1'b1;
				em_req  = cmp.lt_lo || cmp.gt_hi;
			end
		end
	end

	// drop a breakpoint that repeats the value in force before it
	assign em_new = em_req && (em_val != last_q);
	assign ram_we = em_new && (wr_q < CW'(irt_pkg::MAX_ENTRIES));

	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_idx = '0;
		end else if (advance) begin
			rd_idx = IW'(idx_q + CW'(1));
		end else begin
			rd_idx = idx_q[IW-1:0];
		end
	end

	irt_ram #(
		.WIDTH(irt_pkg::ENTRY_W),
		.DEPTH(2 * irt_pkg::MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr({~bank_q, wr_q[IW-1:0]}),
		.wdata({em_val, em_key}),
		.raddr({bank_q, rd_idx}),
		.rdata(rd_data)
	);

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			bank_q       <= 1'b0;
			def_q        <= '0;
			out_valid_q  <= 1'b0;
			lookup_q     <= 1'b0;
			begin_done_q <= 1'b0;
			end_done_q   <= 1'b0;
			idx_q        <= '0;
			wr_q         <= '0;
			status_q     <= irt_pkg::STAT_DONE;
		end else begin
			if (cfg_wr_en) begin
				def_q <= cfg_wr_data;
			end
			// raise the result word as the walk finishes, drop it once taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						lookup_q     <= (s_tuser[0] == irt_pkg::CMD_LOOKUP);
						idx_q        <= '0;
						wr_q         <= '0;
						begin_done_q <= 1'b0;
						end_done_q   <= 1'b0;
						if (s_tuser[0] != irt_pkg::CMD_LOOKUP && in_begin >= in_end) begin
							status_q <= irt_pkg::STAT_EMPTY;
							state_q  <= ST_FIN;
						end else begin
							status_q <= irt_pkg::STAT_DONE;
							state_q  <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					if (advance) begin
						idx_q <= idx_q + CW'(1);
					end
					if (em_new) begin
						wr_q <= wr_q + CW'(1);
					end
					if (em_req && em_key == lo_q && !begin_done_q) begin
						begin_done_q <= 1'b1;
					end else if (em_req && !advance && !end_done_q) begin
						end_done_q <= 1'b1;
					end
					if (done) begin
						if (!lookup_q && wr_q > CW'(irt_pkg::MAX_ENTRIES)) begin
							status_q <= irt_pkg::STAT_FULL;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (!lookup_q && status_q == irt_pkg::STAT_DONE) begin
							bank_q  <= ~bank_q;
							count_q <= wr_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers of the walk and the result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			lo_q   <= in_begin;
			hi_q   <= (s_tuser[0] == irt_pkg::CMD_LOOKUP) ? s_tdata[55:40] : in_end;
			nv_q   <= s_tdata[39:32];
			run_q  <= def_q;
			last_q <= def_q;
		end else if (state_q == ST_EVAL) begin
			// track the value in force at the upper bound
			if (advance && !cmp.gt_hi) begin
				run_q <= rd_val;
			end
			if (em_new) begin
				last_q <= em_val;
			end
		end
		if (state_q == ST_FIN && out_free) begin
			out_data_q <= {6'd0, status_q, lookup_q ? run_q : VW'(0)};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* sv/irt_checker.sv */
module irt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// status code 3 is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:8] != 2'd3))
		else $error("irt: invalid status code");

	// a nonzero status only comes from an assign, which returns a zero value
	a_status_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[9:8] != 2'd0) |-> (m_tdata[7:0] == 8'd0))
		else $error("irt: value on a non-done status");

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("irt: ready right after accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("irt: stalled result changed");

endmodule

bind interval_range_table irt_checker u_irt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
